>>> sv/assert_macros.svh
// Assertion macros used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under async reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under async reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/plbt_pkg.sv
// Types and constants of the price level book.
package plbt_pkg;
  localparam int unsigned PriceLevels = 64;
  localparam int unsigned PriceW = 20;
  localparam int unsigned UnitsW = 32;
  localparam int unsigned QtyW = 20;
  localparam int unsigned AmtW = 40;
  localparam int unsigned CostW = 41;
  localparam int unsigned EntryW = PriceW + UnitsW;

  typedef enum logic [1:0] {
    StArriveStored = 2'd0,
    StArriveDropped = 2'd1,
    StBuyServed = 2'd2,
    StBuyRefused = 2'd3
  } status_e;

  typedef enum logic {
    OpArrive = 1'b0,
    OpBuy = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CMP, S_A_NEW, S_A_SH, S_A_SHW,
    S_B_RD, S_B_MUL, S_B_ACC, S_C_RD, S_C_CHK, S_K_START, S_K_RD, S_K_WR, S_DONE
  } state_e;
endpackage

>>> sv/plbt_mem.sv
// Level table memory: one write port, one registered read port.
module plbt_mem #(
  parameter int unsigned Depth = plbt_pkg::PriceLevels,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [plbt_pkg::EntryW-1:0] wdata_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [plbt_pkg::EntryW-1:0] rdata_o
);
  import plbt_pkg::*;

  logic [EntryW-1:0] mem [Depth];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/plbt_ctrl.sv
// Sequencer and shared datapath: scan, insert shift, buy check, commit, compaction.
`include "assert_macros.svh"
module plbt_ctrl #(
  parameter int unsigned Depth = plbt_pkg::PriceLevels,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [plbt_pkg::QtyW-1:0]   quantity_i,
  input  logic [plbt_pkg::AmtW-1:0]   amount_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        we_o,
  output logic [AddrW-1:0]            waddr_o,
  output logic [plbt_pkg::EntryW-1:0] wdata_o,
  output logic [AddrW-1:0]            raddr_o,
  input  logic [plbt_pkg::EntryW-1:0] rdata_i
);
  import plbt_pkg::*;

  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [CntW-1:0] OneC = CntW'(1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, idx_q, idx_d, ptr_q, ptr_d;
  logic [QtyW-1:0] qty_q, qty_d, left_q, left_d;
  logic [AmtW-1:0] amt_q, amt_d;
  logic [CostW-1:0] cost_q, cost_d;
  logic [2*QtyW-1:0] prod_q, prod_d;
  logic out_valid_q, out_valid_d;
  status_e status_q, status_d, fin_d;
  status_e out_status_q, out_status_d;
  logic fin;

  logic [PriceW-1:0] rprice;
  logic [UnitsW-1:0] runits, left_w;
  logic [UnitsW:0] sum;
  logic [QtyW-1:0] take;

  assign rprice = rdata_i[EntryW-1:UnitsW];
  assign runits = rdata_i[UnitsW-1:0];
  assign left_w = {{(UnitsW-QtyW){1'b0}}, left_q};
  assign sum = {1'b0, runits} + {{(UnitsW+1-QtyW){1'b0}}, qty_q};
  assign take = (runits < left_w) ? runits[QtyW-1:0] : left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ptr_q <= ptr_d;
    qty_q <= qty_d;
    amt_q <= amt_d;
    left_q <= left_d;
    cost_q <= cost_d;
    prod_q <= prod_d;
    status_q <= status_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    ptr_d = ptr_q;
    qty_d = qty_q;
    amt_d = amt_q;
    left_d = left_q;
    cost_d = cost_q;
    prod_d = prod_q;
    status_d = status_q;
    out_status_d = out_status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fin = 1'b0;
    fin_d = StArriveStored;
    we_o = 1'b0;
    waddr_o = idx_q[AddrW-1:0];
    wdata_o = rdata_i;
    raddr_o = idx_q[AddrW-1:0];
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          qty_d = quantity_i;
          amt_d = amount_i;
          left_d = quantity_i;
          cost_d = '0;
          idx_d = '0;
          if (operation_i == OpBuy) state_d = S_B_RD;
          else if (quantity_i == '0) begin
            fin = 1'b1;
            fin_d = StArriveStored;
          end else if (amount_i[AmtW-1:PriceW] != '0) begin
            fin = 1'b1;
            fin_d = StArriveDropped;
          end else state_d = S_A_RD;
        end
      end
      S_A_RD: state_d = (idx_q == cnt_q) ? S_A_NEW : S_A_CMP;
      S_A_CMP: begin
        if (rprice < amt_q[PriceW-1:0]) begin
          idx_d = idx_q + OneC;
          state_d = S_A_RD;
        end else if (rprice == amt_q[PriceW-1:0]) begin
          fin = 1'b1;
          if (sum[UnitsW]) fin_d = StArriveDropped;
          else begin
            we_o = 1'b1;
            wdata_o = {rprice, sum[UnitsW-1:0]};
            fin_d = StArriveStored;
          end
        end else state_d = S_A_NEW;
      end
      S_A_NEW: begin
        if (cnt_q == DepthC) begin
          fin = 1'b1;
          fin_d = StArriveDropped;
        end else begin
          ptr_d = cnt_q;
          state_d = S_A_SH;
        end
      end
      S_A_SH: begin
        // Shift from the top down, then drop the new level in place.
        raddr_o = AddrW'(ptr_q - OneC);
        if (ptr_q == idx_q) begin
          we_o = 1'b1;
          wdata_o = {amt_q[PriceW-1:0], {(UnitsW-QtyW){1'b0}}, qty_q};
          cnt_d = cnt_q + OneC;
          fin = 1'b1;
          fin_d = StArriveStored;
        end else state_d = S_A_SHW;
      end
      S_A_SHW: begin
        we_o = 1'b1;
        waddr_o = ptr_q[AddrW-1:0];
        ptr_d = ptr_q - OneC;
        state_d = S_A_SH;
      end
      S_B_RD: begin
        if (idx_q == cnt_q || left_q == '0) begin
          if (left_q != '0 || cost_q > {1'b0, amt_q}) begin
            fin = 1'b1;
            fin_d = StBuyRefused;
          end else begin
            left_d = qty_q;
            idx_d = '0;
            state_d = S_C_RD;
          end
        end else state_d = S_B_MUL;
      end
      S_B_MUL: begin
        prod_d = take * rprice;
        left_d = left_q - take;
        idx_d = idx_q + OneC;
        state_d = S_B_ACC;
      end
      S_B_ACC: begin
        cost_d = cost_q + {1'b0, prod_q};
        state_d = S_B_RD;
      end
      S_C_RD: state_d = (idx_q == cnt_q) ? S_K_START : S_C_CHK;
      S_C_CHK: begin
        if (left_w >= runits) begin
          left_d = left_q - runits[QtyW-1:0];
          idx_d = idx_q + OneC;
          state_d = S_C_RD;
        end else begin
          if (left_q != '0) begin
            we_o = 1'b1;
            wdata_o = {rprice, runits - left_w};
          end
          state_d = S_K_START;
        end
      end
      S_K_START: begin
        ptr_d = idx_q;
        if (idx_q == '0) begin
          fin = 1'b1;
          fin_d = StBuyServed;
        end else state_d = S_K_RD;
      end
      S_K_RD: begin
        raddr_o = ptr_q[AddrW-1:0];
        if (ptr_q == cnt_q) begin
          cnt_d = cnt_q - idx_q;
          fin = 1'b1;
          fin_d = StBuyServed;
        end else state_d = S_K_WR;
      end
      S_K_WR: begin
        we_o = 1'b1;
        waddr_o = AddrW'(ptr_q - idx_q);
        ptr_d = ptr_q + OneC;
        state_d = S_K_RD;
      end
      S_DONE: begin
        // Hand the status to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_status_d = status_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) begin
      status_d = fin_d;
      state_d = S_DONE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;

  `ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= DepthC, "level count past depth")
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != S_IDLE,
              "accepted request did not start")
  `ASSERT_IMP(a_we_state, clk_i, rst_ni, we_o,
              state_q == S_A_CMP || state_q == S_A_SH || state_q == S_A_SHW ||
              state_q == S_C_CHK || state_q == S_K_WR, "table write outside a write step")
endmodule

>>> sv/price_level_book_bulk_take_unit.sv
// Top level of the price level book with bulk take.
//  channel | signals                                   | direction
//  request | in_valid_i/in_ready_o, operation, qty, amt | in
//  result  | out_valid_o/out_ready_i, status_o           | out
// One request at a time; ready only while the sequencer idles.
// Arrive: read and compare per scanned level, read and write per shifted level.
// Buy: read/mul/add per checked level, read/check per taken, read/write per moved.
// All steps share the one table memory; only the buy cost uses the one multiplier.
// Reset empties the book at once; no clearing pass.
// A result still waiting in the output register holds the next one in the final step.
module price_level_book_bulk_take_unit #(
  parameter int unsigned PriceLevels = plbt_pkg::PriceLevels
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      operation_i,
  input  logic [plbt_pkg::QtyW-1:0] quantity_i,
  input  logic [plbt_pkg::AmtW-1:0] amount_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o
);
  import plbt_pkg::*;

  localparam int unsigned AddrW = $clog2(PriceLevels);

  logic we;
  logic [AddrW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  plbt_ctrl #(.Depth(PriceLevels)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .quantity_i, .amount_i,
    .out_valid_o, .out_ready_i, .status_o,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  plbt_mem #(.Depth(PriceLevels)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
endmodule
